// ----- sv/mec_pkg.sv -----
// ----------------------------------------------------------------------------
// mec_pkg - shared types for the Mandelbrot escape-time core
// Transfer payloads, per-cell control word and configuration codes.
// ----------------------------------------------------------------------------
package mec_pkg;

    // one point c, signed Q4.28
    typedef struct packed {
        logic signed [31:0] c_real;
        logic signed [31:0] c_imag;
    } point_t;

    typedef struct packed {
        logic [7:0] escape_count;
        logic       escaped;
    } result_t;

    // control word that travels down the cell chain with each point
    typedef struct packed {
        logic       valid;
        logic       done;
        logic [7:0] count;
    } ctl_t;

    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITERATIONS   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_THRESHOLD = 1'b1;

    localparam logic [7:0]  MAX_ITERATIONS_RESET   = 8'd128;
    localparam logic [31:0] ESCAPE_THRESHOLD_RESET = 32'd1342177280;  // 5.0

endpackage

// ----- sv/mec_mul.sv -----
// ----------------------------------------------------------------------------
// mec_mul - two-stage signed multiplier
// Splits operand b in halves, registers the two partial products, then
// registers their sum. Full-width product.
// ----------------------------------------------------------------------------
module mec_mul #(
    parameter int W = 36
) (
    input  logic                  clk,
    input  logic                  en,
    input  logic signed [W-1:0]   a,
    input  logic signed [W-1:0]   b,
    output logic signed [2*W-1:0] p
);

    localparam int H    = W / 2;
    localparam int HI_W = W - H;
    localparam int P_W  = 2 * W;

    logic signed [W+H:0]    p_lo_next;
    logic signed [W+H:0]    p_lo_reg;
    logic signed [W+HI_W-1:0] p_hi_next;
    logic signed [W+HI_W-1:0] p_hi_reg;
    logic signed [P_W-1:0]  p_next;
    logic signed [P_W-1:0]  p_reg;
    logic signed [P_W-1:0]  hi_ext;
    logic signed [P_W-1:0]  lo_ext;

    // low half of b taken as unsigned, high half carries the sign
    assign p_lo_next = a * $signed({1'b0, b[H-1:0]});
    assign p_hi_next = a * $signed(b[W-1:H]);

    assign hi_ext = P_W'(p_hi_reg);
    assign lo_ext = P_W'(p_lo_reg);
    assign p_next = (hi_ext <<< H) + lo_ext;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_lo_reg <= p_lo_next;
            p_hi_reg <= p_hi_next;
            p_reg    <= p_next;
        end
    end

    assign p = p_reg;

endmodule

// ----- sv/mec_cell.sv -----
// ----------------------------------------------------------------------------
// mec_cell - one iteration of the escape-time chain
// Squares z, tests the squared magnitude of the incoming z against the threshold and
// forms the next z = z*z + c. Three register stages.
// ----------------------------------------------------------------------------
module mec_cell
    import mec_pkg::*;
#(
    parameter int FRAC_BITS = 28,
    parameter int INDEX     = 0
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic [7:0]                  limit,
    input  logic [31:0]                 threshold,
    input  ctl_t                        ctl_in,
    input  point_t                      c_in,
    input  logic signed [FRAC_BITS+7:0] re_in,
    input  logic signed [FRAC_BITS+7:0] im_in,
    output ctl_t                        ctl_out,
    output point_t                      c_out,
    output logic signed [FRAC_BITS+7:0] re_out,
    output logic signed [FRAC_BITS+7:0] im_out
);

    localparam int Z_W   = FRAC_BITS + 8;
    localparam int P_W   = 2 * Z_W;
    localparam int D_W   = P_W + 1;
    localparam int S_W   = P_W - FRAC_BITS + 34;
    localparam int CMP_W = P_W + 32;

    function automatic logic signed [Z_W-1:0] sat_z(input logic signed [S_W-1:0] v);
        logic [S_W-Z_W:0] top;
        top = v[S_W-1:Z_W-1];
        if (top == '0 || top == '1)
            sat_z = v[Z_W-1:0];
        else if (v[S_W-1])
            sat_z = {1'b1, {(Z_W-1){1'b0}}};
        else
            sat_z = {1'b0, {(Z_W-1){1'b1}}};
    endfunction

    logic signed [P_W-1:0] rr;
    logic signed [P_W-1:0] ii;
    logic signed [P_W-1:0] ri;

    ctl_t   ctl1_reg;
    ctl_t   ctl2_reg;
    point_t c1_reg;
    point_t c2_reg;

    logic signed [D_W-1:0] diff;
    logic signed [D_W-1:0] diff_sh;
    logic signed [P_W-1:0] ri_sh;
    logic signed [S_W-1:0] re_sum;
    logic signed [S_W-1:0] im_sum;
    logic [CMP_W-1:0]      mag_sum;
    logic [CMP_W-1:0]      bound;
    logic                  test_en;

    ctl_t                  ctl_next;
    ctl_t                  ctl_out_reg;
    point_t                c_out_reg;
    logic signed [Z_W-1:0] re_next;
    logic signed [Z_W-1:0] im_next;
    logic signed [Z_W-1:0] re_out_reg;
    logic signed [Z_W-1:0] im_out_reg;

    mec_mul #(.W(Z_W)) u_mul_rr (.clk(clk), .en(en), .a(re_in), .b(re_in), .p(rr));
    mec_mul #(.W(Z_W)) u_mul_ii (.clk(clk), .en(en), .a(im_in), .b(im_in), .p(ii));
    mec_mul #(.W(Z_W)) u_mul_ri (.clk(clk), .en(en), .a(re_in), .b(im_in), .p(ri));

    // cell k sees z after k iterations: an escape here belongs to index k-1
    assign test_en = (INDEX != 0) && (INDEX <= int'(limit));

    assign mag_sum = CMP_W'(rr) + CMP_W'(ii);
    assign bound   = CMP_W'(threshold) << FRAC_BITS;

    assign diff    = D_W'(rr) - D_W'(ii);
    assign diff_sh = diff >>> FRAC_BITS;
    assign ri_sh   = ri >>> (FRAC_BITS - 1);
    assign re_sum  = S_W'(diff_sh) + S_W'(c2_reg.c_real);
    assign im_sum  = S_W'(ri_sh) + S_W'(c2_reg.c_imag);
    assign re_next = sat_z(re_sum);
    assign im_next = sat_z(im_sum);

    always_comb
    begin
        ctl_next = ctl2_reg;
        if (ctl2_reg.valid && !ctl2_reg.done && test_en && (mag_sum > bound))
        begin
            ctl_next.done  = 1'b1;
            ctl_next.count = 8'(INDEX - 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg    <= '0;
            ctl2_reg    <= '0;
            ctl_out_reg <= '0;
        end
        else if (en)
        begin
            ctl1_reg    <= ctl_in;
            ctl2_reg    <= ctl1_reg;
            ctl_out_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c1_reg     <= c_in;
            c2_reg     <= c1_reg;
            c_out_reg  <= c2_reg;
            re_out_reg <= re_next;
            im_out_reg <= im_next;
        end
    end

    assign ctl_out = ctl_out_reg;
    assign c_out   = c_out_reg;
    assign re_out  = re_out_reg;
    assign im_out  = im_out_reg;

endmodule

// ----- sv/mandelbrot_escape_count_core.sv -----
// ----------------------------------------------------------------------------
// mandelbrot_escape_count_core - Mandelbrot escape-time counter
// A chain of ITER_LIMIT+1 iteration cells computes the escape index of
// one point per cycle unless a result is stalled.
// ----------------------------------------------------------------------------
//  channel  | signals                          | transfer when
//  ---------+----------------------------------+---------------------------
//  point    | point_valid, point_stall, point  | valid && !stall
//  result   | result_valid, result_stall, result | valid && !stall
//  config   | cfg_wr_en, cfg_index, cfg_data   | cfg_wr_en
//
//  One point enters per cycle unless a result is stalled; each point passes
//  the three register stages of every cell (split multiply, then update).
//  The chain advances as one: a stalled result holds every cell and stalls
//  the point input in the same cycle.
//  Reset clears all valid bits and loads max_iterations = 128 and
//  escape_threshold = 5.0.
// ----------------------------------------------------------------------------
module mandelbrot_escape_count_core
    import mec_pkg::*;
#(
    parameter int ITER_LIMIT = 128,
    parameter int FRAC_BITS  = 28
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 point_valid,
    output logic                 point_stall,
    input  point_t               point,
    output logic                 result_valid,
    input  logic                 result_stall,
    output result_t              result,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    localparam int Z_W   = FRAC_BITS + 8;
    localparam int E_W   = Z_W + 33;
    localparam int NCELL = ITER_LIMIT + 1;

    function automatic logic signed [Z_W-1:0] sat_c(input logic signed [31:0] c);
        logic signed [E_W-1:0] v;
        logic [E_W-Z_W:0]      top;
        v   = E_W'(c);
        top = v[E_W-1:Z_W-1];
        if (top == '0 || top == '1)
            sat_c = v[Z_W-1:0];
        else if (v[E_W-1])
            sat_c = {1'b1, {(Z_W-1){1'b0}}};
        else
            sat_c = {1'b0, {(Z_W-1){1'b1}}};
    endfunction

    logic [7:0]  max_iter_reg;
    logic [7:0]  max_iter_next;
    logic [31:0] thr_reg;
    logic [31:0] thr_next;
    logic [7:0]  limit;
    logic        en;

    ctl_t                  link_ctl [NCELL+1];
    point_t                link_c   [NCELL+1];
    logic signed [Z_W-1:0] link_re  [NCELL+1];
    logic signed [Z_W-1:0] link_im  [NCELL+1];

    logic    result_valid_reg;
    logic    result_valid_next;
    result_t result_reg;
    result_t result_next;

    // configuration
    always_comb
    begin
        max_iter_next = max_iter_reg;
        thr_next      = thr_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_MAX_ITERATIONS:   max_iter_next = cfg_data[7:0];
                CFG_ESCAPE_THRESHOLD: thr_next      = cfg_data;
                default:              ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_iter_reg <= MAX_ITERATIONS_RESET;
            thr_reg      <= ESCAPE_THRESHOLD_RESET;
        end
        else
        begin
            max_iter_reg <= max_iter_next;
            thr_reg      <= thr_next;
        end
    end

    assign limit = (int'(max_iter_reg) > ITER_LIMIT) ? 8'(ITER_LIMIT) : max_iter_reg;

    // whole chain moves unless a finished result is held
    assign en          = !(result_valid_reg && result_stall);
    assign point_stall = !en;

    assign link_ctl[0] = '{valid: point_valid, done: 1'b0, count: 8'd0};
    assign link_c[0]   = point;
    assign link_re[0]  = sat_c(point.c_real);
    assign link_im[0]  = sat_c(point.c_imag);

    for (genvar k = 0; k < NCELL; k++)
    begin : g_cell
        mec_cell #(
            .FRAC_BITS(FRAC_BITS),
            .INDEX    (k)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .limit    (limit),
            .threshold(thr_reg),
            .ctl_in   (link_ctl[k]),
            .c_in     (link_c[k]),
            .re_in    (link_re[k]),
            .im_in    (link_im[k]),
            .ctl_out  (link_ctl[k+1]),
            .c_out    (link_c[k+1]),
            .re_out   (link_re[k+1]),
            .im_out   (link_im[k+1])
        );
    end

    assign result_valid_next        = link_ctl[NCELL].valid;
    assign result_next.escaped      = link_ctl[NCELL].done;
    assign result_next.escape_count = link_ctl[NCELL].done ? link_ctl[NCELL].count : limit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (en)
            result_valid_reg <= result_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // an escape index lies below the limit; no escape reports the limit itself
    a_count_vs_limit: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |->
            (result_reg.escaped ? (result_reg.escape_count < limit)
                                : (result_reg.escape_count == limit)))
        else $error("escape_count inconsistent with iteration limit");

    // a done flag only appears on a valid chain slot
    a_done_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
        link_ctl[NCELL].done |-> link_ctl[NCELL].valid)
        else $error("done flag on an empty chain slot");

    // a held result freezes the end of the chain
    a_chain_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(link_ctl[NCELL]))
        else $error("chain moved while result held");

endmodule
